FILE: design/afrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrf_pkg: shared types and constants of the frame receive filter
// Register indexes, the start delimiter, reset values of the control
// registers, the parser state encoding and the result record.
// ----------------------------------------------------------------------------
package afrf_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned PosWidth    = 9;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [ByteWidth-1:0] StartByte = 8'h7E;

   // Reset values of the control registers
   localparam logic [ByteWidth-1:0] MaxLenReset = 8'd84;
   localparam logic [ByteWidth-1:0] TypeAReset  = 8'h90;
   localparam logic [ByteWidth-1:0] TypeBReset  = 8'h91;

   // Fixed frame positions
   localparam logic [PosWidth-1:0] TypePos      = 9'd3;
   localparam logic [PosWidth-1:0] FirstBodyPos = 9'd4;
   localparam logic [PosWidth-1:0] LastOffset   = 9'd3;
   localparam logic [PosWidth-1:0] LenOffset    = 9'd4;

   // Control register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MAX_LEN = 2'd0,
      CSR_TYPE_A  = 2'd1,
      CSR_TYPE_B  = 2'd2
   } csr_index_type;

   // Parser phase, one-hot
   typedef enum logic [4:0] {
      PH_HUNT   = 5'b00001,
      PH_LEN_HI = 5'b00010,
      PH_LEN_LO = 5'b00100,
      PH_TYPE   = 5'b01000,
      PH_BODY   = 5'b10000
   } phase_type;

   // Control register values seen by the parser
   typedef struct packed {
      logic [ByteWidth-1:0] max_data_length;
      logic [ByteWidth-1:0] accepted_type_a;
      logic [ByteWidth-1:0] accepted_type_b;
   } cfg_type;

   // One emitted frame byte
   typedef struct packed {
      logic [ByteWidth-1:0] frame_byte;
      logic [PosWidth-1:0]  position;
      logic [PosWidth-1:0]  frame_length;
      logic                 first_flag;
      logic                 last_flag;
   } result_type;

endpackage

FILE: design/afrf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrf_if: channel interfaces of the frame receive filter
// Received byte channel and frame byte result channel, valid/ready each.
// ----------------------------------------------------------------------------
interface afrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic [8:0] position;
   logic [8:0] frame_length;
   logic       first_flag;
   logic       last_flag;

   modport source (output valid, output frame_byte, output position,
                   output frame_length, output first_flag, output last_flag,
                   input ready);
   modport sink   (input valid, input frame_byte, input position,
                   input frame_length, input first_flag, input last_flag,
                   output ready);
endinterface

FILE: design/api_frame_receive_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_receive_filter: start-delimited length frame receiver
// Hunts for 0x7E, reads a big-endian length and a type byte, and emits the
// kept frame bytes from the type byte through the checksum.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock while results are taken and gives
// at most one frame byte per received byte. A byte passes the input register and
// the parser logic into the result register, which drives the result port; the
// sustained rate is one byte per cycle while the result channel does not stall.
// While a result waits, the input register holds the next byte and the input
// stalls until the result is taken. Header bytes and bytes of rejected frames
// give no result.
// A frame is kept when its type byte equals one of the two accepted types and
// its length field is at most the configured maximum; the checksum is passed
// through unchecked. Write the control registers only while the block is idle.
// ----------------------------------------------------------------------------
module api_frame_receive_filter
   import afrf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   afrf_req_if.sink               req_if,
   afrf_rsp_if.source             rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_wdata
);

   cfg_type              cfg;
   logic                 take;
   logic                 in_valid;
   logic [ByteWidth-1:0] in_byte;
   result_type           rsp_data;

   afrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   afrf_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_rx_byte (req_if.rx_byte),
      .req_ready   (req_if.ready),
      .take        (take),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   afrf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid),
      .in_byte   (in_byte),
      .take      (take),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_data  (rsp_data)
   );

   // Drive the result channel payload
   assign rsp_if.frame_byte   = rsp_data.frame_byte;
   assign rsp_if.position     = rsp_data.position;
   assign rsp_if.frame_length = rsp_data.frame_length;
   assign rsp_if.first_flag   = rsp_data.first_flag;
   assign rsp_if.last_flag    = rsp_data.last_flag;

endmodule

FILE: design/afrf_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrf_csr: control registers
// Holds the length limit and the two accepted frame types.
// ----------------------------------------------------------------------------
module afrf_csr
   import afrf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the write; ignore unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_LEN: cfg_in.max_data_length = csr_wdata;
            CSR_TYPE_A:  cfg_in.accepted_type_a = csr_wdata;
            CSR_TYPE_B:  cfg_in.accepted_type_b = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_data_length <= MaxLenReset;
         cfg_ff.accepted_type_a <= TypeAReset;
         cfg_ff.accepted_type_b <= TypeBReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/afrf_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrf_in_stage: input register
// Captures one received byte and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module afrf_in_stage
   import afrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [ByteWidth-1:0] req_rx_byte,
   output logic                 req_ready,
   input  logic                 take,
   output logic                 in_valid,
   output logic [ByteWidth-1:0] in_byte
);

   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] byte_ff;

   // Accept a byte when the register is empty or the held byte moves on in the same cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload on each transaction
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

FILE: design/afrf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrf_parser: frame parser and result register
// Walks the header, applies the type and length filter, and loads each kept
// frame byte into the result register.
// ----------------------------------------------------------------------------
module afrf_parser
   import afrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 in_valid,
   input  logic [ByteWidth-1:0] in_byte,
   output logic                 take,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output result_type           rsp_data
);

   phase_type            phase_ff, phase_in;
   logic                 len_hi_nz_ff, len_hi_nz_in;
   logic [ByteWidth-1:0] len_lo_ff, len_lo_in;
   logic [PosWidth-1:0]  index_ff, index_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           result_ff, result_in;

   logic                 room;
   logic                 keep;
   logic [PosWidth-1:0]  last_pos;

   // Process a byte only when the result register has room
   assign room = !rsp_valid_ff || rsp_ready;
   assign take = in_valid && room;

   assign last_pos = {1'b0, len_lo_ff} + LastOffset;
   assign keep = ((in_byte == cfg.accepted_type_a) || (in_byte == cfg.accepted_type_b))
                 && !len_hi_nz_ff && (len_lo_ff <= cfg.max_data_length);

   // Next phase and result
   always_comb begin
      phase_in              = phase_ff;
      len_hi_nz_in          = len_hi_nz_ff;
      len_lo_in             = len_lo_ff;
      index_in              = index_ff;
      rsp_valid_in          = 1'b0;
      result_in.frame_byte  = in_byte;
      result_in.position    = index_ff;
      result_in.frame_length = {1'b0, len_lo_ff} + LenOffset;
      result_in.first_flag  = 1'b0;
      result_in.last_flag   = (index_ff == last_pos);
      case (phase_ff)
         PH_LEN_HI: begin
            len_hi_nz_in = (in_byte != '0);
            len_lo_in    = '0;
            phase_in     = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_lo_in = in_byte;
            phase_in  = PH_TYPE;
         end
         PH_TYPE: begin
            result_in.position   = TypePos;
            result_in.first_flag = 1'b1;
            result_in.last_flag  = (len_lo_ff == '0);
            if (keep) begin
               rsp_valid_in = 1'b1;
               if (len_lo_ff == '0) begin
                  phase_in = PH_HUNT;
                  index_in = '0;
               end else begin
                  phase_in = PH_BODY;
                  index_in = FirstBodyPos;
               end
            end else begin
               phase_in = PH_HUNT;
               index_in = '0;
            end
         end
         PH_BODY: begin
            rsp_valid_in = 1'b1;
            if (index_ff == last_pos) begin
               phase_in = PH_HUNT;
               index_in = '0;
            end else begin
               index_in = index_ff + 1'b1;
            end
         end
         default: begin
            phase_in = (in_byte == StartByte) ? PH_LEN_HI : PH_HUNT;
            index_in = '0;
         end
      endcase
   end

   // Advance parser state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         len_hi_nz_ff <= 1'b0;
         len_lo_ff    <= '0;
         index_ff     <= '0;
      end else if (take) begin
         phase_ff     <= phase_in;
         len_hi_nz_ff <= len_hi_nz_in;
         len_lo_ff    <= len_lo_in;
         index_ff     <= index_in;
      end
   end

   // Result valid: load when there is room, hold otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (room) begin
         rsp_valid_ff <= take && rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && rsp_valid_in) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = result_ff;

endmodule

FILE: design/afrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrf_checker: port-level checks of the frame receive filter
// Watches the result channel for frame bookkeeping and reset behavior.
// ----------------------------------------------------------------------------
module afrf_checker
   import afrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [ByteWidth-1:0] frame_byte,
   input  logic [PosWidth-1:0]  position,
   input  logic [PosWidth-1:0]  frame_length,
   input  logic                 first_flag,
   input  logic                 last_flag
);

   // Hold a stalled transaction
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_byte)
         && $stable(position) && $stable(first_flag) && $stable(last_flag))
      else $error("stalled result changed");

   // First byte of a frame is always the type byte
   a_first_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && first_flag |-> position == TypePos)
      else $error("first flag off the type byte");

   // Last flag marks exactly the final position of the frame
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_flag == (position == frame_length - 9'd1))
         && (position < frame_length) && (frame_length >= LenOffset))
      else $error("position outside frame or last flag wrong");

   // Return to an empty result channel after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind api_frame_receive_filter afrf_checker u_afrf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .frame_byte   (rsp_if.frame_byte),
   .position     (rsp_if.position),
   .frame_length (rsp_if.frame_length),
   .first_flag   (rsp_if.first_flag),
   .last_flag    (rsp_if.last_flag)
);
